// ===== rtl/core/nus_pkg.sv =====
// Shared constants and types of the NAL unit splitter.
package nus_pkg;

   // Bytes in an Annex B start code (00 00 00 01).
   localparam int START_CODE_BYTES = 4;
   // Most results a single input item can cause.
   localparam int MAX_RESULTS = 6;
   // Widest length prefix, in bytes.
   localparam logic [2:0] MAX_PREFIX_BYTES = 3'd4;
   // Register value that selects start-code mode.
   localparam logic [2:0] MODE_START_CODE = 3'd0;
   // Last byte of a start code.
   localparam logic [7:0] START_CODE_TAIL = 8'h01;

   // One NAL byte with its unit flags.
   typedef struct packed {
      logic [7:0] nal_byte;
      logic       nal_first;
      logic       nal_last;
      logic       truncated;
   } nus_result_type;

   // All results caused by one input item.
   typedef struct packed {
      nus_result_type [MAX_RESULTS-1:0] entry;
      logic [2:0]                       count;
   } nus_batch_type;

endpackage

// ===== rtl/core/nus_req_if.sv =====
// Input channel of the NAL unit splitter: one packet byte per item.
interface nus_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_packet;

   modport source (output valid, output data_byte, output end_of_packet, input ready);
   modport sink (input valid, input data_byte, input end_of_packet, output ready);
endinterface

// ===== rtl/core/nus_rsp_if.sv =====
// Result channel of the NAL unit splitter: one NAL byte with flags per item.
interface nus_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] nal_byte;
   logic       nal_first;
   logic       nal_last;
   logic       truncated;
   logic       batch_last;

   modport source (output valid, output nal_byte, output nal_first, output nal_last,
                   output truncated, output batch_last, input ready);
   modport sink (input valid, input nal_byte, input nal_first, input nal_last,
                 input truncated, input batch_last, output ready);
endinterface

// ===== rtl/core/nus_parse.sv =====
// Packet parser: start-code window, held byte, length prefix and unit state.
module nus_parse
   import nus_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   nus_req_if.sink       req_chan,
   input  logic          queue_space,
   input  logic          csr_write_en,
   input  logic [2:0]    csr_write_data,
   output logic          batch_load,
   output nus_batch_type batch
);

   logic [2:0]  lfb_ff;
   logic [7:0]  win_ff [0:START_CODE_BYTES-1];
   logic [7:0]  win_in [0:START_CODE_BYTES-1];
   logic [2:0]  fill_ff, fill_in;
   logic [7:0]  held_ff, held_in;
   logic        held_valid_ff, held_valid_in;
   logic        inside_ff, inside_in;
   logic        started_ff, started_in;
   logic [2:0]  seen_ff, seen_in;
   logic [31:0] accum_ff, accum_in;
   logic [31:0] left_ff, left_in;
   logic        accept;

   // An item is taken whenever the result queue can hold its batch.
   assign req_chan.ready = queue_space;
   assign accept         = req_chan.valid && queue_space;
   assign batch_load     = accept;

   // Next state and the batch of results for the item on the input.
   always_comb begin
      logic [2:0] n;
      logic [2:0] m;
      logic [7:0] b0;
      logic [7:0] tail_bytes [0:START_CODE_BYTES];
      logic [2:0] width;
      logic       last;
      logic       trunc;
      logic [7:0] b;
      logic       eop;

      b     = req_chan.data_byte;
      eop   = req_chan.end_of_packet;
      n     = 3'd0;
      m     = 3'd0;
      b0    = 8'd0;
      last  = 1'b0;
      trunc = 1'b0;
      width = (lfb_ff > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : lfb_ff;
      for (int k = 0; k <= START_CODE_BYTES; k++) begin
         tail_bytes[k] = 8'd0;
      end
      for (int k = 0; k < START_CODE_BYTES; k++) begin
         win_in[k] = win_ff[k];
      end
      fill_in       = fill_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      inside_in     = inside_ff;
      started_in    = started_ff;
      seen_in       = seen_ff;
      accum_in      = accum_ff;
      left_in       = left_ff;
      batch         = '0;

      if (lfb_ff == MODE_START_CODE) begin
         // A full window either holds a start code or releases its oldest byte.
         if (fill_ff == 3'(START_CODE_BYTES)) begin
            if (win_ff[0] == 8'd0 && win_ff[1] == 8'd0 && win_ff[2] == 8'd0 &&
                win_ff[3] == START_CODE_TAIL) begin
               if (inside_ff && held_valid_ff) begin
                  batch.entry[n] = nus_result_type'{nal_byte: held_ff,
                     nal_first: !started_in, nal_last: 1'b1, truncated: 1'b0};
                  started_in = 1'b1;
                  n = n + 3'd1;
               end
               held_valid_in = 1'b0;
               inside_in     = 1'b1;
               started_in    = 1'b0;
               fill_in       = 3'd0;
            end else begin
               b0        = win_ff[0];
               win_in[0] = win_ff[1];
               win_in[1] = win_ff[2];
               win_in[2] = win_ff[3];
               fill_in   = 3'(START_CODE_BYTES - 1);
               if (inside_ff) begin
                  if (held_valid_ff) begin
                     batch.entry[n] = nus_result_type'{nal_byte: held_ff,
                        nal_first: !started_in, nal_last: 1'b0, truncated: 1'b0};
                     started_in = 1'b1;
                     n = n + 3'd1;
                  end
                  held_in       = b0;
                  held_valid_in = 1'b1;
               end
            end
         end
         win_in[fill_in[1:0]] = b;
         fill_in = fill_in + 3'd1;

         // At packet end the held byte and the window close the unit.
         if (eop && inside_in) begin
            if (held_valid_in) begin
               tail_bytes[m] = held_in;
               m = m + 3'd1;
            end
            for (int k = 0; k < START_CODE_BYTES; k++) begin
               if (3'(k) < fill_in) begin
                  tail_bytes[m] = win_in[k];
                  m = m + 3'd1;
               end
            end
            for (int k = 0; k <= START_CODE_BYTES; k++) begin
               if (3'(k) < m) begin
                  batch.entry[n] = nus_result_type'{nal_byte: tail_bytes[k],
                     nal_first: !started_in, nal_last: (3'(k) == m - 3'd1),
                     truncated: 1'b0};
                  started_in = 1'b1;
                  n = n + 3'd1;
               end
            end
         end
      end else begin
         if (!inside_ff) begin
            // Gather the big-endian length prefix.
            accum_in = {accum_ff[23:0], b};
            seen_in  = seen_ff + 3'd1;
            if (seen_in >= width) begin
               left_in  = accum_in;
               accum_in = 32'd0;
               seen_in  = 3'd0;
               if (left_in != 32'd0) begin
                  inside_in  = 1'b1;
                  started_in = 1'b0;
               end
            end
         end else begin
            // Payload byte; a packet end before the count runs out truncates.
            left_in = left_ff - 32'd1;
            last    = (left_in == 32'd0);
            trunc   = !last && eop;
            batch.entry[n] = nus_result_type'{nal_byte: b, nal_first: !started_ff,
               nal_last: last || eop, truncated: trunc};
            started_in = 1'b1;
            n = n + 3'd1;
            if (left_in == 32'd0) begin
               inside_in = 1'b0;
            end
         end
      end

      batch.count = n;
   end

   // Register and packet state; a register write or a packet end restarts the packet.
   always_ff @(posedge clock) begin
      if (reset || csr_write_en || (accept && req_chan.end_of_packet)) begin
         for (int k = 0; k < START_CODE_BYTES; k++) begin
            win_ff[k] <= 8'd0;
         end
         fill_ff       <= 3'd0;
         held_ff       <= 8'd0;
         held_valid_ff <= 1'b0;
         inside_ff     <= 1'b0;
         started_ff    <= 1'b0;
         seen_ff       <= 3'd0;
         accum_ff      <= 32'd0;
         left_ff       <= 32'd0;
      end else if (accept) begin
         for (int k = 0; k < START_CODE_BYTES; k++) begin
            win_ff[k] <= win_in[k];
         end
         fill_ff       <= fill_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         inside_ff     <= inside_in;
         started_ff    <= started_in;
         seen_ff       <= seen_in;
         accum_ff      <= accum_in;
         left_ff       <= left_in;
      end
      if (reset) begin
         lfb_ff <= MODE_START_CODE;
      end else if (csr_write_en) begin
         lfb_ff <= csr_write_data;
      end
   end

endmodule

// ===== rtl/core/nus_batch_queue.sv =====
// Result queue: holds one item's batch and hands it out one result per cycle while the output is ready.
module nus_batch_queue
   import nus_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          batch_load,
   input  nus_batch_type batch,
   output logic          queue_space,
   nus_rsp_if.source     rsp_chan
);

   nus_result_type [MAX_RESULTS-1:0] entry_ff;
   logic [2:0] ptr_ff, ptr_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       pending;
   logic       on_last;
   logic       take;

   assign pending     = (ptr_ff != cnt_ff);
   assign on_last     = (3'(ptr_ff + 3'd1) == cnt_ff);
   assign take        = pending && rsp_chan.ready;
   assign queue_space = !pending || (on_last && rsp_chan.ready);

   // Present the current result; the final one of a batch closes it.
   assign rsp_chan.valid      = pending;
   assign rsp_chan.nal_byte   = entry_ff[ptr_ff].nal_byte;
   assign rsp_chan.nal_first  = entry_ff[ptr_ff].nal_first;
   assign rsp_chan.nal_last   = entry_ff[ptr_ff].nal_last;
   assign rsp_chan.truncated  = entry_ff[ptr_ff].truncated;
   assign rsp_chan.batch_last = on_last;

   // Read pointer and fill count.
   always_comb begin
      ptr_in = ptr_ff;
      cnt_in = cnt_ff;
      if (batch_load) begin
         ptr_in = 3'd0;
         cnt_in = batch.count;
      end else if (take && on_last) begin
         ptr_in = 3'd0;
         cnt_in = 3'd0;
      end else if (take) begin
         ptr_in = ptr_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= 3'd0;
         cnt_ff <= 3'd0;
      end else begin
         ptr_ff <= ptr_in;
         cnt_ff <= cnt_in;
      end
      if (batch_load) begin
         entry_ff <= batch.entry;
      end
   end

endmodule

// ===== rtl/core/nal_unit_splitter.sv =====
// Top level of the NAL unit splitter.
//
//   Channel    Direction  Handshake      Contents
//   req_chan   in         valid/ready    data_byte, end_of_packet
//   rsp_chan   out        valid/ready    nal_byte, nal_first, nal_last, truncated, batch_last
//   csr_*      in         write enable   length_field_bytes (0 = start codes, 1..4 prefix)
//
// An item is parsed in the cycle it is accepted and its results are registered in the
// result queue; the first result is offered in the next cycle.
// The queue hands out one result per cycle while rsp_chan is ready; an item causing
// several results (up to six) holds the input until the last of them is taken.
// Reset is synchronous and clears the register and all packet state; a register
// write or a packet end restarts the packet. A stall on rsp_chan backs up to req_chan.
module nal_unit_splitter
   import nus_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   nus_req_if.sink    req_chan,
   nus_rsp_if.source  rsp_chan,
   input  logic       csr_write_en,
   input  logic [2:0] csr_write_data
);

   nus_batch_type batch;
   logic          batch_load;
   logic          queue_space;

   // Parser with packet state.
   nus_parse u_parse (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .queue_space    (queue_space),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .batch_load     (batch_load),
      .batch          (batch)
   );

   // Result queue towards the output channel.
   nus_batch_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .batch_load  (batch_load),
      .batch       (batch),
      .queue_space (queue_space),
      .rsp_chan    (rsp_chan)
   );

endmodule

// ===== tb/tb_nal_unit_splitter.sv =====
// Self-checking testbench of the NAL unit splitter, in start-code and length-prefix modes.
module tb_nal_unit_splitter;
   import nus_pkg::*;

   // One packet byte waiting to be offered on the input channel.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_packet;
   } pkt_byte_type;

   // One NAL byte that the splitter should hand out, with its flags.
   typedef struct packed {
      nus_result_type res;
      logic           batch_last;
   } nal_expect_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic       csr_write_en;
   logic [2:0] csr_write_data;

   nus_req_if req_chan ();
   nus_rsp_if rsp_chan ();

   nal_unit_splitter u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   pkt_byte_type   pending_bytes_q[$];
   nal_expect_type expected_nal_q[$];
   nal_expect_type step_results[$];
   logic [7:0]     packet_bytes[$];
   int             mismatch_count = 0;
   bit             calm = 1'b0;
   int             gap_left = 0;
   int             stall_left = 0;

   // Predictor state: register copy and per-packet parsing state.
   logic [2:0]  prefix_cfg;
   logic [7:0]  sc_window [START_CODE_BYTES];
   logic [2:0]  sc_fill;
   logic [7:0]  held_byte;
   logic        held_valid;
   logic        in_unit;
   logic        unit_begun;
   logic [2:0]  hdr_seen;
   logic [31:0] len_accum;
   logic [31:0] payload_left;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task report_mismatch(input string what);
      $display("%0t: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void clear_packet_state();
      foreach (sc_window[i]) sc_window[i] = 8'h00;
      sc_fill = '0;
      held_byte = '0;
      held_valid = 1'b0;
      in_unit = 1'b0;
      unit_begun = 1'b0;
      hdr_seen = '0;
      len_accum = '0;
      payload_left = '0;
   endfunction

   function automatic void emit_nal(input logic [7:0] b, input logic first, input logic last,
                                    input logic trunc);
      nal_expect_type e;
      e.res.nal_byte = b;
      e.res.nal_first = first;
      e.res.nal_last = last;
      e.res.truncated = trunc;
      e.batch_last = 1'b0;
      step_results.push_back(e);
   endfunction

   function automatic void emit_unit_byte(input logic [7:0] b, input logic last);
      emit_nal(b, !unit_begun, last, 1'b0);
      unit_begun = 1'b1;
   endfunction

   // Start-code mode: a four-byte window decides whether the oldest byte is data or code.
   function automatic void step_annexb(input logic [7:0] b, input logic eop);
      logic [7:0] oldest;
      logic [7:0] tail[$];
      if (sc_fill >= START_CODE_BYTES) begin
         if (sc_window[0] == 8'h00 && sc_window[1] == 8'h00 && sc_window[2] == 8'h00 &&
             sc_window[3] == START_CODE_TAIL) begin
            if (in_unit && held_valid) emit_unit_byte(held_byte, 1'b1);
            held_valid = 1'b0;
            in_unit = 1'b1;
            unit_begun = 1'b0;
            sc_fill = '0;
         end else begin
            oldest = sc_window[0];
            sc_window[0] = sc_window[1];
            sc_window[1] = sc_window[2];
            sc_window[2] = sc_window[3];
            sc_fill = 3'(START_CODE_BYTES - 1);
            if (in_unit) begin
               if (held_valid) emit_unit_byte(held_byte, 1'b0);
               held_byte = oldest;
               held_valid = 1'b1;
            end
         end
      end
      sc_window[sc_fill[1:0]] = b;
      sc_fill++;
      // At packet end everything still held belongs to the open unit.
      if (eop && in_unit) begin
         if (held_valid) tail.push_back(held_byte);
         for (int k = 0; k < sc_fill && k < START_CODE_BYTES; k++) tail.push_back(sc_window[k]);
         foreach (tail[j]) emit_unit_byte(tail[j], j == tail.size() - 1);
      end
   endfunction

   // Length-prefix mode: gather the big-endian prefix, then pass the payload through.
   function automatic void step_prefixed(input logic [7:0] b, input logic eop);
      logic [2:0] width;
      logic       first;
      logic       last;
      logic       trunc;
      width = (prefix_cfg > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES : prefix_cfg;
      if (!in_unit) begin
         len_accum = {len_accum[23:0], b};
         hdr_seen++;
         if (hdr_seen >= width) begin
            payload_left = len_accum;
            len_accum = '0;
            hdr_seen = '0;
            if (payload_left != 0) begin
               in_unit = 1'b1;
               unit_begun = 1'b0;
            end
         end
      end else begin
         first = !unit_begun;
         unit_begun = 1'b1;
         payload_left--;
         last = (payload_left == 0);
         trunc = 1'b0;
         if (!last && eop) begin
            last = 1'b1;
            trunc = 1'b1;
         end
         emit_nal(b, first, last, trunc);
         if (payload_left == 0) in_unit = 1'b0;
      end
   endfunction

   // Works out the NAL bytes that one accepted packet byte causes and queues them.
   function automatic void predict_nal_step(input logic [7:0] b, input logic eop);
      nal_expect_type e;
      step_results.delete();
      if (prefix_cfg == MODE_START_CODE) step_annexb(b, eop);
      else step_prefixed(b, eop);
      foreach (step_results[j]) begin
         e = step_results[j];
         e.batch_last = (j == step_results.size() - 1);
         expected_nal_q.push_back(e);
      end
      if (eop) clear_packet_state();
   endfunction

   // Input driver: offers queued bytes, with short random gaps between items.
   always @(posedge clock) begin : byte_driver
      pkt_byte_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_nal_step(req_chan.data_byte, req_chan.end_of_packet);
         if (!req_chan.valid || req_chan.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_chan.valid <= 1'b0;
            end else if (!calm && pending_bytes_q.size() > 0 && $urandom_range(0, 4) == 0) begin
               gap_left = $urandom_range(0, 2);
               req_chan.valid <= 1'b0;
            end else if (pending_bytes_q.size() > 0) begin
               nxt = pending_bytes_q.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.data_byte <= nxt.data_byte;
               req_chan.end_of_packet <= nxt.end_of_packet;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: stalls at random and checks each accepted item in order.
   always @(posedge clock) begin : nal_monitor
      nal_expect_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_nal_q.size() == 0) begin
               report_mismatch($sformatf("byte %02h arrived with nothing expected",
                                         rsp_chan.nal_byte));
            end else begin
               want = expected_nal_q.pop_front();
               if (rsp_chan.nal_byte !== want.res.nal_byte)
                  report_mismatch($sformatf("nal_byte %02h, expected %02h",
                                            rsp_chan.nal_byte, want.res.nal_byte));
               if (rsp_chan.nal_first !== want.res.nal_first)
                  report_mismatch($sformatf("nal_first %b, expected %b on byte %02h",
                                            rsp_chan.nal_first, want.res.nal_first,
                                            want.res.nal_byte));
               if (rsp_chan.nal_last !== want.res.nal_last)
                  report_mismatch($sformatf("nal_last %b, expected %b on byte %02h",
                                            rsp_chan.nal_last, want.res.nal_last,
                                            want.res.nal_byte));
               if (rsp_chan.truncated !== want.res.truncated)
                  report_mismatch($sformatf("truncated %b, expected %b on byte %02h",
                                            rsp_chan.truncated, want.res.truncated,
                                            want.res.nal_byte));
               if (rsp_chan.batch_last !== want.batch_last)
                  report_mismatch($sformatf("batch_last %b, expected %b on byte %02h",
                                            rsp_chan.batch_last, want.batch_last,
                                            want.res.nal_byte));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Stream bytes lean towards zero so that near start codes turn up often.
   function automatic logic [7:0] stream_byte();
      return ($urandom_range(0, 2) == 0) ? 8'h00 : 8'($urandom_range(0, 255));
   endfunction

   function automatic void build_annexb_packet();
      packet_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6)) packet_bytes.push_back(stream_byte());
      end else begin
         repeat ($urandom_range(0, 2)) packet_bytes.push_back(stream_byte());
         repeat ($urandom_range(1, 3)) begin
            // Now and then a three-byte code, which does not separate units.
            if ($urandom_range(0, 5) != 0) packet_bytes.push_back(8'h00);
            packet_bytes.push_back(8'h00);
            packet_bytes.push_back(8'h00);
            packet_bytes.push_back(START_CODE_TAIL);
            repeat ($urandom_range(0, 4)) packet_bytes.push_back(stream_byte());
         end
      end
   endfunction

   function automatic void build_prefixed_packet(input int width);
      logic [31:0] unit_len;
      bit          wild;
      packet_bytes.delete();
      if ($urandom_range(0, 7) == 0) begin
         repeat ($urandom_range(1, 6)) packet_bytes.push_back(stream_byte());
      end else begin
         repeat ($urandom_range(1, 3)) begin
            // A wild prefix declares a long unit that the packet end cuts short.
            wild = ($urandom_range(0, 5) == 0);
            unit_len = wild ? $urandom : 32'($urandom_range(0, 4));
            for (int i = width - 1; i >= 0; i--) packet_bytes.push_back(unit_len[8*i +: 8]);
            repeat (wild ? $urandom_range(1, 4) : unit_len)
               packet_bytes.push_back(8'($urandom_range(0, 255)));
         end
      end
   endfunction

   // Queues the packet for the driver, sometimes ending it early; returns its length.
   function automatic int launch_packet(input bit may_cut);
      pkt_byte_type item;
      int           keep;
      if (may_cut && packet_bytes.size() > 1 && $urandom_range(0, 3) == 0) begin
         keep = $urandom_range(1, packet_bytes.size() - 1);
         while (packet_bytes.size() > keep) void'(packet_bytes.pop_back());
      end
      foreach (packet_bytes[i]) begin
         item.data_byte = packet_bytes[i];
         item.end_of_packet = (i == packet_bytes.size() - 1);
         pending_bytes_q.push_back(item);
      end
      return packet_bytes.size();
   endfunction

   function automatic void push_directed(input logic [127:0] seq, input int count);
      packet_bytes.delete();
      for (int i = 0; i < count; i++) packet_bytes.push_back(seq[8*(count-1-i) +: 8]);
      void'(launch_packet(1'b0));
   endfunction

   task write_prefix_cfg(input logic [2:0] value);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      prefix_cfg = value;
      clear_packet_state();
   endtask

   // Random packets for the current mode, then wait until every result is in.
   task run_random_packets(input int target);
      int added;
      added = 0;
      while (added < target) begin
         if (prefix_cfg == MODE_START_CODE) build_annexb_packet();
         else build_prefixed_packet(int'((prefix_cfg > MAX_PREFIX_BYTES) ? MAX_PREFIX_BYTES
                                                                          : prefix_cfg));
         added += launch_packet(1'b1);
      end
      while (pending_bytes_q.size() != 0 || req_chan.valid || expected_nal_q.size() != 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin
      req_chan.valid = 1'b0;
      req_chan.data_byte = '0;
      req_chan.end_of_packet = 1'b0;
      rsp_chan.ready = 1'b0;
      csr_write_en = 1'b0;
      csr_write_data = '0;
      prefix_cfg = MODE_START_CODE;
      clear_packet_state();
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Start-code mode from reset: a leading byte, adjacent codes, and a code that
      // ends the packet and so counts as data.
      push_directed(120'hAA_00_00_00_01_65_00_00_00_01_00_00_00_01_80, 15);
      push_directed(72'h00_00_00_01_FF_00_00_00_01, 9);
      run_random_packets(8);

      // One-byte prefixes: a zero length, a whole unit, and a unit cut by the packet end.
      write_prefix_cfg(3'd1);
      push_directed(48'h00_02_AA_55_03_FF, 6);
      run_random_packets(6);

      write_prefix_cfg(3'd2);
      run_random_packets(6);
      write_prefix_cfg(3'd3);
      run_random_packets(6);
      write_prefix_cfg(MAX_PREFIX_BYTES);
      run_random_packets(6);
      // Values above four behave as four.
      write_prefix_cfg(3'd7);
      run_random_packets(6);

      // Last stretch without idling on either side.
      calm = 1'b1;
      write_prefix_cfg(MODE_START_CODE);
      run_random_packets(8);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
